### rtl/core/maag_pkg.sv
// ----------------------------------------------------------------------------
// maag_pkg
// Shared constants, codes and control types of the array address generator.
// ----------------------------------------------------------------------------
package maag_pkg;

    // Table depth and subscript width.
    localparam int MAX_DIMS    = 8;
    localparam int INDEX_WIDTH = 16;

    // Derived widths.
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W = $clog2(MAX_DIMS + 1);
    localparam int EXT_W = INDEX_WIDTH + 2;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int ELEM_W     = 16;
    localparam int DCOUNT_W   = 4;
    localparam int SEL_W      = 3;
    localparam int FIELD_W    = 16;
    localparam int IN_DATA_W  = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_COUNT = 2'd2;

    // Input transaction kinds.
    localparam logic ACT_INDEX  = 1'b0;
    localparam logic ACT_BOUNDS = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_bounds;
        logic capture_index;
        logic mul_step;
        logic acc_step;
        logic scale_step;
    } ctrl_cmd_t;

    // Status towards the controller.
    typedef struct packed {
        logic is_last;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/core/maag_ctrl.sv
// ----------------------------------------------------------------------------
// maag_ctrl
// Sequencer that steps one transaction through the shared multiplier.
// ----------------------------------------------------------------------------
module maag_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_action,
    input  maag_pkg::ctrl_status_t status,
    output logic                  s_tready,
    output logic                  emit,
    output maag_pkg::ctrl_cmd_t   cmd
);

    maag_pkg::state_t state_reg, state_next;
    logic             accept;

    assign s_tready = (state_reg == maag_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next        = state_reg;
        cmd               = '0;
        emit              = 1'b0;
        unique case (state_reg)
            maag_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_action == maag_pkg::ACT_BOUNDS) begin
                        cmd.load_bounds = 1'b1;
                    end else begin
                        cmd.capture_index = 1'b1;
                        state_next        = maag_pkg::ST_MUL;
                    end
                end
            end
            maag_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = maag_pkg::ST_ACC;
            end
            maag_pkg::ST_ACC: begin
                cmd.acc_step = 1'b1;
                state_next   = status.is_last ? maag_pkg::ST_SCALE : maag_pkg::ST_IDLE;
            end
            maag_pkg::ST_SCALE: begin
                cmd.scale_step = 1'b1;
                state_next     = maag_pkg::ST_EMIT;
            end
            maag_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    emit       = 1'b1;
                    state_next = maag_pkg::ST_IDLE;
                end
            end
            default: state_next = maag_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= maag_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/maag_datapath.sv
// ----------------------------------------------------------------------------
// maag_datapath
// Bound tables, configuration registers, accumulator and shared multiplier.
// ----------------------------------------------------------------------------
module maag_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [maag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [maag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  maag_pkg::ctrl_cmd_t               cmd,
    input  logic [maag_pkg::SEL_W-1:0]        dim_select,
    input  logic [maag_pkg::INDEX_WIDTH-1:0]  lower_value,
    input  logic [maag_pkg::INDEX_WIDTH-1:0]  upper_value,
    input  logic [maag_pkg::INDEX_WIDTH-1:0]  index_value,
    output logic                              is_last,
    output logic [maag_pkg::ADDR_W-1:0]       address_value
);

    localparam int AW = maag_pkg::ADDR_W;
    localparam int IW = maag_pkg::INDEX_WIDTH;
    localparam int EW = maag_pkg::EXT_W;
    localparam int DW = maag_pkg::DIM_W;
    localparam int CW = maag_pkg::CNT_W;

    // Configuration registers.
    logic [AW-1:0]                   base_reg;
    logic [maag_pkg::ELEM_W-1:0]     elem_reg;
    logic [maag_pkg::DCOUNT_W-1:0]   dcount_reg;

    // Bound tables; entries are undefined until loaded.
    logic [IW-1:0] lower_table [maag_pkg::MAX_DIMS];
    logic [EW-1:0] extent_table [maag_pkg::MAX_DIMS];

    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] prod_reg;
    logic [IW-1:0] idx_reg;
    logic [DW-1:0] dim_reg;
    logic          last_reg;
    logic [DW-1:0] counter_reg, counter_next;

    logic [CW-1:0] count_eff;
    logic [DW-1:0] dim_cur;
    logic [CW:0]   dim_plus_one;
    logic [DW-1:0] load_slot;
    logic          load_ok;
    logic [EW-1:0] extent_new;
    logic [AW-1:0] mul_a, mul_b, mul_p;
    logic [AW-1:0] idx_ext, lower_ext;

    // Dimensions in use: zero counts as one, anything above the table as full.
    always_comb begin
        if (dcount_reg == '0) begin
            count_eff = CW'(1);
        end else if (32'(dcount_reg) > maag_pkg::MAX_DIMS) begin
            count_eff = CW'(maag_pkg::MAX_DIMS);
        end else begin
            count_eff = CW'(dcount_reg);
        end
    end

    always_comb begin
        if (CW'(counter_reg) >= count_eff) begin
            dim_cur = DW'(count_eff - CW'(1));
        end else begin
            dim_cur = counter_reg;
        end
        dim_plus_one = (CW + 1)'(dim_cur) + (CW + 1)'(1);
    end

    assign load_slot  = DW'(dim_select);
    assign load_ok    = (32'(dim_select) < maag_pkg::MAX_DIMS);
    assign extent_new = {{2{upper_value[IW-1]}}, upper_value}
                      - {{2{lower_value[IW-1]}}, lower_value} + EW'(1);

    // Shared multiplier: extent during a fold, element size for the scale.
    assign mul_a = acc_reg;
    assign mul_b = cmd.scale_step ? AW'(elem_reg)
                 : {{(AW - EW){extent_table[dim_reg][EW-1]}}, extent_table[dim_reg]};
    assign mul_p = mul_a * mul_b;

    assign idx_ext   = {{(AW - IW){idx_reg[IW-1]}}, idx_reg};
    assign lower_ext = {{(AW - IW){lower_table[dim_reg][IW-1]}}, lower_table[dim_reg]};

    always_comb begin
        acc_next     = acc_reg;
        counter_next = counter_reg;
        if (cmd.acc_step) begin
            acc_next = prod_reg + idx_ext - lower_ext;
            if (last_reg) begin
                counter_next = '0;
            end else begin
                counter_next = dim_reg + DW'(1);
            end
        end else if (cmd.scale_step) begin
            acc_next = '0;
        end
    end

    assign is_last       = last_reg;
    assign address_value = base_reg + prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            elem_reg    <= maag_pkg::ELEM_W'(1);
            dcount_reg  <= maag_pkg::DCOUNT_W'(1);
            acc_reg     <= '0;
            counter_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    maag_pkg::REG_BASE_ADDRESS:    base_reg   <= cfg_wdata;
                    maag_pkg::REG_ELEMENT_SIZE:    elem_reg   <= cfg_wdata[maag_pkg::ELEM_W-1:0];
                    maag_pkg::REG_DIMENSION_COUNT: dcount_reg <= cfg_wdata[maag_pkg::DCOUNT_W-1:0];
                    default: ;
                endcase
            end
            acc_reg     <= acc_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_bounds && load_ok) begin
            lower_table[load_slot]  <= lower_value;
            extent_table[load_slot] <= extent_new;
        end
        if (cmd.capture_index) begin
            idx_reg  <= index_value;
            dim_reg  <= dim_cur;
            last_reg <= (dim_plus_one >= (CW + 1)'(count_eff));
        end
        if (cmd.mul_step || cmd.scale_step) begin
            prod_reg <= mul_p;
        end
    end

endmodule

### rtl/core/multidim_array_address_generator.sv
// ----------------------------------------------------------------------------
// multidim_array_address_generator
// Byte address of an element of a row-major array with signed bounds.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Content
// s_        in         s_tvalid/s_tready   bound load or one subscript
// m_        out        m_tvalid/m_tready   element address
// cfg_      in         cfg_wr_en           base, element size, dimension count
//
// A bound transaction is written into the tables as it is taken, and the
// block stays ready for the next. A subscript transaction is taken, the
// running sum is multiplied by the extent through the one shared 32 by 32
// multiplier, and its offset is added, after which the next transaction can
// be taken. The subscript of the last dimension then also scales by the
// element size and adds the base into the output register.
// Reset is synchronous and active low; it restores the register defaults and
// clears the accumulator and dimension counter, while the bound tables stay
// undefined until loaded. A finished address waits in the output register,
// and new transactions are taken meanwhile; only a second address stalls,
// holding in the final step until the first has been taken.
//
module multidim_array_address_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, from bit 0: dim_select[2:0], lower_value[15:0], upper_value[15:0],
    // index_value[15:0], zero padding.
    input  logic [maag_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: action (0 = subscript, 1 = load bounds).
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, from bit 0: address[31:0].
    output logic [maag_pkg::ADDR_W-1:0]         m_tdata,
    // Configuration writes.
    input  logic                                cfg_wr_en,
    input  logic [maag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [maag_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SW = maag_pkg::SEL_W;
    localparam int FW = maag_pkg::FIELD_W;

    maag_pkg::ctrl_cmd_t    cmd;
    maag_pkg::ctrl_status_t status;
    logic                   emit;
    logic                   is_last;
    logic [maag_pkg::ADDR_W-1:0] address_value;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [maag_pkg::ADDR_W-1:0] m_tdata_reg;

    // The output register is free when empty or being emptied this cycle.
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.is_last  = is_last;

    maag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .emit     (emit),
        .cmd      (cmd)
    );

    maag_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .dim_select    (s_tdata[SW-1:0]),
        .lower_value   (s_tdata[SW+FW-1:SW]),
        .upper_value   (s_tdata[SW+2*FW-1:SW+FW]),
        .index_value   (s_tdata[SW+3*FW-1:SW+2*FW]),
        .is_last       (is_last),
        .address_value (address_value)
    );

    // Result holding register: loaded on emit, cleared once taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= address_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
